### src/rpru_pkg.sv
// Shared types and constants for the parity repair and unpack block.
package rpru_pkg;

    localparam int DISK_W     = 8;
    localparam int DC_W       = 4;
    localparam int BB_W       = 6;
    localparam int SC_W       = 10;
    localparam int NIB_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_DISK_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ODD   = 2'd3;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_CLOSE,
        ST_PAD,
        ST_STATUS
    } rpru_state_t;

    typedef struct packed {
        logic col_write;
        logic drain_step;
        logic stripe_close;
        logic emit_pad;
        logic emit_status;
    } rpru_cmd_t;

    typedef struct packed {
        logic stripe_end;
        logic drain_last;
        logic set_bad;
        logic set_end;
        logic pad_needed;
        logic step_ok;
        logic out_free;
    } rpru_stat_t;

endpackage

### src/rpru_ctrl.sv
// Controller state machine that sequences column intake, stripe drain and set end.
module rpru_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rpru_pkg::rpru_stat_t stat,
    output rpru_pkg::rpru_cmd_t  cmd
);
    import rpru_pkg::*;

    rpru_state_t state_reg;
    rpru_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && stat.stripe_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.set_bad || (stat.step_ok && stat.drain_last))
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                state_next = stat.set_end ? ST_PAD : ST_IDLE;
            end
            ST_PAD:
            begin
                if (!stat.pad_needed || stat.out_free)
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.col_write = in_valid;
            end
            ST_DRAIN:
            begin
                cmd.drain_step = !stat.set_bad && stat.step_ok;
            end
            ST_CLOSE:
            begin
                cmd.stripe_close = 1'b1;
            end
            ST_PAD:
            begin
                cmd.emit_pad = stat.pad_needed && stat.out_free;
            end
            ST_STATUS:
            begin
                cmd.emit_status = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### src/rpru_dp.sv
// Datapath: registers, column repair, stripe store, nibble packer and output register.
module rpru_dp #(
    parameter int MAX_DISKS      = 8,
    parameter int MAX_BLOCK_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [rpru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpru_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [rpru_pkg::DISK_W-1:0]       disk_bits,
    input  logic [rpru_pkg::DISK_W-1:0]       erased_mask,
    input  rpru_pkg::rpru_cmd_t               cmd,
    output rpru_pkg::rpru_stat_t              stat,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              kind,
    output logic [rpru_pkg::NIB_W-1:0]        nibble,
    output logic                              set_valid,
    output logic                              last
);
    import rpru_pkg::*;

    localparam int CW = (MAX_BLOCK_BITS > 1) ? $clog2(MAX_BLOCK_BITS) : 1;
    localparam int DW = $clog2(MAX_DISKS);

    logic [DC_W-1:0]  disk_count_reg;
    logic [BB_W-1:0]  block_bits_reg;
    logic [SC_W-1:0]  stripe_count_reg;
    logic             parity_odd_reg;

    logic [DC_W-1:0]  dc_eff;
    logic [BB_W-1:0]  bb_eff;
    logic [SC_W-1:0]  sc_eff;

    logic [MAX_DISKS-1:0] store_mem [MAX_BLOCK_BITS];
    logic [MAX_DISKS-1:0] store_rd_reg;
    logic [CW-1:0]        rd_addr;

    logic [CW-1:0]    column_index_reg;
    logic [CW-1:0]    j_reg;
    logic [DW-1:0]    d_reg;
    logic [DW-1:0]    pd_reg;
    logic [SC_W-1:0]  stripe_index_reg;
    logic             set_bad_reg;
    logic [NIB_W-1:0] partial_reg;
    logic [1:0]       partial_count_reg;

    logic             out_valid_reg;
    logic             kind_reg;
    logic [NIB_W-1:0] nibble_reg;
    logic             set_valid_reg;
    logic             last_reg;

    logic [MAX_DISKS-1:0] dmask;
    logic [MAX_DISKS-1:0] bits_m;
    logic [MAX_DISKS-1:0] er_m;
    logic [MAX_DISKS-1:0] known;
    logic [MAX_DISKS-1:0] col;
    logic                 parity;
    logic                 col_bad;

    logic [DW-1:0]    pd_wrap;
    logic [DC_W-1:0]  d_plus1;
    logic [DC_W-1:0]  d_skip;
    logic [DC_W-1:0]  pd_plus1;
    logic             disk_done;
    logic             j_last;
    logic             rd_bit;
    logic             load_nib;
    logic [NIB_W-1:0] pad_nib;

    // Out-of-range register values act as the nearest legal value.
    always_comb
    begin
        dc_eff = disk_count_reg;
        if (disk_count_reg < DC_W'(2))
        begin
            dc_eff = DC_W'(2);
        end
        else if (disk_count_reg > DC_W'(MAX_DISKS))
        begin
            dc_eff = DC_W'(MAX_DISKS);
        end
        bb_eff = block_bits_reg;
        if (block_bits_reg == '0)
        begin
            bb_eff = BB_W'(1);
        end
        else if (block_bits_reg > BB_W'(MAX_BLOCK_BITS))
        begin
            bb_eff = BB_W'(MAX_BLOCK_BITS);
        end
        sc_eff = (stripe_count_reg == '0) ? SC_W'(1) : stripe_count_reg;
    end

    always_comb
    begin
        for (int k = 0; k < MAX_DISKS; k++)
        begin
            dmask[k] = (DC_W'(k) < dc_eff);
        end
        bits_m  = disk_bits[MAX_DISKS-1:0] & dmask;
        er_m    = erased_mask[MAX_DISKS-1:0] & dmask;
        known   = bits_m & ~er_m;
        parity  = ^known;
        col     = known;
        col_bad = 1'b0;
        if ((er_m & (er_m - MAX_DISKS'(1))) != '0)
        begin
            col_bad = 1'b1;
        end
        else if (er_m != '0)
        begin
            if (parity ^ parity_odd_reg)
            begin
                col = known | er_m;
            end
        end
        else if (parity != parity_odd_reg)
        begin
            col_bad = 1'b1;
        end
    end

    // The store row for the next drain step is read into a register ahead of that step.
    always_comb
    begin
        pd_wrap   = (DC_W'(pd_reg) >= dc_eff) ? '0 : pd_reg;
        d_plus1   = DC_W'(d_reg) + DC_W'(1);
        d_skip    = (d_plus1 == DC_W'(pd_reg)) ? d_plus1 + DC_W'(1) : d_plus1;
        disk_done = (d_skip >= dc_eff);
        j_last    = ((BB_W + 1)'(j_reg) + (BB_W + 1)'(1)) >= {1'b0, bb_eff};
        rd_addr   = !cmd.drain_step ? j_reg : (j_last ? '0 : j_reg + CW'(1));
        pd_plus1  = DC_W'(pd_reg) + DC_W'(1);
        rd_bit    = store_rd_reg[d_reg];
        load_nib  = cmd.drain_step && (partial_count_reg == 2'd3);
        case (partial_count_reg)
            2'd1:    pad_nib = {partial_reg[0], 3'b000};
            2'd2:    pad_nib = {partial_reg[1:0], 2'b00};
            2'd3:    pad_nib = {partial_reg[2:0], 1'b0};
            default: pad_nib = '0;
        endcase
    end

    always_comb
    begin
        stat.stripe_end = ((BB_W + 1)'(column_index_reg) + (BB_W + 1)'(1))
                          >= {1'b0, bb_eff};
        stat.drain_last = j_last && disk_done;
        stat.set_bad    = set_bad_reg;
        stat.set_end    = ((SC_W + 1)'(stripe_index_reg) + (SC_W + 1)'(1))
                          >= {1'b0, sc_eff};
        stat.pad_needed = !set_bad_reg && (partial_count_reg != 2'd0);
        stat.out_free   = !out_valid_reg || out_ready;
        stat.step_ok    = stat.out_free || (partial_count_reg != 2'd3);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.col_write)
        begin
            store_mem[column_index_reg] <= col;
        end
        if (cmd.col_write && (column_index_reg == rd_addr))
        begin
            store_rd_reg <= col;
        end
        else
        begin
            store_rd_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_count_reg   <= DC_W'(2);
            block_bits_reg   <= BB_W'(1);
            stripe_count_reg <= SC_W'(1);
            parity_odd_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DISK_COUNT:   disk_count_reg   <= cfg_data[DC_W-1:0];
                CFG_BLOCK_BITS:   block_bits_reg   <= cfg_data[BB_W-1:0];
                CFG_STRIPE_COUNT: stripe_count_reg <= cfg_data[SC_W-1:0];
                CFG_PARITY_ODD:   parity_odd_reg   <= cfg_data[0];
                default:          parity_odd_reg   <= parity_odd_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_index_reg  <= '0;
            j_reg             <= '0;
            d_reg             <= '0;
            pd_reg            <= '0;
            stripe_index_reg  <= '0;
            set_bad_reg       <= 1'b0;
            partial_reg       <= '0;
            partial_count_reg <= '0;
        end
        else
        begin
            if (cmd.col_write)
            begin
                set_bad_reg <= set_bad_reg | col_bad;
                if (stat.stripe_end)
                begin
                    column_index_reg <= '0;
                    pd_reg           <= pd_wrap;
                    j_reg            <= '0;
                    d_reg            <= (pd_wrap == '0) ? DW'(1) : '0;
                end
                else
                begin
                    column_index_reg <= column_index_reg + CW'(1);
                end
            end
            if (cmd.drain_step)
            begin
                if (partial_count_reg == 2'd3)
                begin
                    partial_reg       <= '0;
                    partial_count_reg <= '0;
                end
                else
                begin
                    partial_reg       <= {partial_reg[NIB_W-2:0], rd_bit};
                    partial_count_reg <= partial_count_reg + 2'd1;
                end
                if (j_last)
                begin
                    j_reg <= '0;
                    d_reg <= d_skip[DW-1:0];
                end
                else
                begin
                    j_reg <= j_reg + CW'(1);
                end
            end
            if (cmd.stripe_close)
            begin
                pd_reg <= (pd_plus1 >= dc_eff) ? '0 : pd_plus1[DW-1:0];
                if (!stat.set_end)
                begin
                    stripe_index_reg <= stripe_index_reg + SC_W'(1);
                end
            end
            if (cmd.emit_status)
            begin
                stripe_index_reg  <= '0;
                pd_reg            <= '0;
                set_bad_reg       <= 1'b0;
                partial_reg       <= '0;
                partial_count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_nib || cmd.emit_pad || cmd.emit_status)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_nib)
        begin
            kind_reg      <= KIND_DATA;
            nibble_reg    <= {partial_reg[NIB_W-2:0], rd_bit};
            set_valid_reg <= 1'b1;
            last_reg      <= 1'b0;
        end
        else if (cmd.emit_pad)
        begin
            kind_reg      <= KIND_DATA;
            nibble_reg    <= pad_nib;
            set_valid_reg <= 1'b1;
            last_reg      <= 1'b0;
        end
        else if (cmd.emit_status)
        begin
            kind_reg      <= KIND_STATUS;
            nibble_reg    <= '0;
            set_valid_reg <= !set_bad_reg;
            last_reg      <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign nibble    = nibble_reg;
    assign set_valid = set_valid_reg;
    assign last      = last_reg;

    a_drain_good_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_step |-> !set_bad_reg)
        else $error("drain step taken on an invalid set");

    a_drain_skips_parity: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_step |-> d_reg != pd_reg)
        else $error("parity disk bits were unpacked");

    a_pad_partial: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_pad |-> (partial_count_reg != 2'd0) && !set_bad_reg)
        else $error("pad item without a partial nibble");

    a_status_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_status |=> (stripe_index_reg == '0) && (partial_count_reg == 2'd0)
                            && !set_bad_reg && out_valid_reg && last_reg)
        else $error("set state not cleared after status item");

endmodule

### src/raid_parity_repair_unpack.sv
// A column that does not end a stripe is taken while the block is idle.
// A stripe end drains one data bit per cycle, except while a full nibble waits on a held
// output, and skips the drain once the set is invalid; the stripe then closes.
// A set end then emits the padded nibble, if bits are left, and the status item as the output frees.
// Reset clears control state, config and out_valid; the store and item fields hold no value.
// Top level of the parity repair and unpack block.
module raid_parity_repair_unpack #(
    parameter int MAX_DISKS      = 8,
    parameter int MAX_BLOCK_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rpru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rpru_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rpru_pkg::DISK_W-1:0]       disk_bits,
    input  logic [rpru_pkg::DISK_W-1:0]       erased_mask,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              kind,
    output logic [rpru_pkg::NIB_W-1:0]        nibble,
    output logic                              set_valid,
    output logic                              last
);
    import rpru_pkg::*;

    rpru_cmd_t  cmd;
    rpru_stat_t stat;

    assign cfg_ready = 1'b1;

    rpru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rpru_dp #(
        .MAX_DISKS      (MAX_DISKS),
        .MAX_BLOCK_BITS (MAX_BLOCK_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .disk_bits   (disk_bits),
        .erased_mask (erased_mask),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .kind        (kind),
        .nibble      (nibble),
        .set_valid   (set_valid),
        .last        (last)
    );

endmodule

### tb/sv/raid_parity_repair_unpack_test.sv
// Self-checking testbench for the parity repair and unpack block, driven by directed and random columns.
module raid_parity_repair_unpack_test;
    import rpru_pkg::*;

    localparam int MAX_DISKS      = 8;
    localparam int MAX_BLOCK_BITS = 32;
    localparam int STALL_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int RANDOM_COLUMNS = 100;

    typedef struct packed {
        logic              kind;
        logic [NIB_W-1:0]  nibble;
        logic              set_valid;
        logic              last;
    } unpack_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [DISK_W-1:0]     disk_bits;
    logic [DISK_W-1:0]     erased_mask;
    logic                  out_valid;
    logic                  out_ready;
    logic                  kind;
    logic [NIB_W-1:0]      nibble;
    logic                  set_valid;
    logic                  last;

    logic [DC_W-1:0]       disk_count_reg;
    logic [BB_W-1:0]       block_bits_reg;
    logic [SC_W-1:0]       stripe_count_reg;
    logic                  parity_odd_reg;
    logic [DISK_W-1:0]     column_store [MAX_BLOCK_BITS];
    int                    column_pos;
    int                    stripe_pos;
    int                    parity_disk_pos;
    logic                  set_bad;
    logic [NIB_W-1:0]      nibble_acc;
    int                    nibble_fill;

    unpack_item_t          nibble_stream [$];
    int                    error_count;
    int                    quiet_cycles = 0;
    bit                    no_idle;

    raid_parity_repair_unpack DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .disk_bits   (disk_bits),
        .erased_mask (erased_mask),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .nibble      (nibble),
        .set_valid   (set_valid),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int eff_disks();
        int d;
        d = disk_count_reg;
        if (d < 2) d = 2;
        if (d > MAX_DISKS) d = MAX_DISKS;
        return d;
    endfunction

    function automatic int eff_block_bits();
        int b;
        b = block_bits_reg;
        if (b < 1) b = 1;
        if (b > MAX_BLOCK_BITS) b = MAX_BLOCK_BITS;
        return b;
    endfunction

    function automatic int eff_stripes();
        int s;
        s = stripe_count_reg;
        if (s < 1) s = 1;
        return s;
    endfunction

    function automatic unpack_item_t make_item(logic k, logic [NIB_W-1:0] n, logic v, logic l);
        unpack_item_t item;
        item.kind      = k;
        item.nibble    = n;
        item.set_valid = v;
        item.last      = l;
        return item;
    endfunction

    function automatic int idle_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Builds a column with correct parity unless a noisy set picks a broken one.
    function automatic void make_column(input bit noisy, output logic [DISK_W-1:0] bits,
                                        output logic [DISK_W-1:0] erased);
        int                dc;
        int                r;
        int                p;
        int                q;
        bit                want_wrong;
        logic [DISK_W-1:0] dmask;
        dc     = eff_disks();
        dmask  = DISK_W'((1 << dc) - 1);
        bits   = DISK_W'($urandom);
        erased = DISK_W'($urandom) & ~dmask;
        r      = $urandom_range(0, 99);
        if (noisy && r < 15)
        begin
            p = $urandom_range(0, dc - 1);
            q = (p + $urandom_range(1, dc - 1)) % dc;
            erased |= DISK_W'(1 << p) | DISK_W'(1 << q);
        end
        else
        begin
            want_wrong = noisy && r < 30;
            if ((($countones(bits & dmask) % 2) == parity_odd_reg) == want_wrong)
                bits ^= DISK_W'(1 << $urandom_range(0, dc - 1));
            if (!want_wrong && $urandom_range(0, 1) == 1)
                erased |= DISK_W'(1 << $urandom_range(0, dc - 1));
        end
    endfunction

    task automatic repair_and_pack(input logic [DISK_W-1:0] bits_in,
                                   input logic [DISK_W-1:0] erased_in);
        int                dc;
        int                bb;
        int                sc;
        int                known_ones;
        logic [DISK_W-1:0] dmask;
        logic [DISK_W-1:0] erased;
        logic [DISK_W-1:0] column;
        dc         = eff_disks();
        bb         = eff_block_bits();
        sc         = eff_stripes();
        dmask      = DISK_W'((1 << dc) - 1);
        erased     = erased_in & dmask;
        column     = bits_in & dmask & ~erased;
        known_ones = $countones(column);
        if ($countones(erased) > 1)
            set_bad = 1'b1;
        else if (erased != '0)
        begin
            if ((known_ones % 2) != parity_odd_reg)
                column |= erased;
        end
        else if ((known_ones % 2) != parity_odd_reg)
            set_bad = 1'b1;
        column_store[column_pos % MAX_BLOCK_BITS] = column;

        if (column_pos + 1 < bb)
        begin
            column_pos = (column_pos + 1) % MAX_BLOCK_BITS;
            return;
        end

        column_pos = 0;
        if (parity_disk_pos >= dc) parity_disk_pos = 0;
        if (!set_bad)
        begin
            for (int d = 0; d < dc; d++)
            begin
                if (d == parity_disk_pos) continue;
                for (int j = 0; j < bb; j++)
                begin
                    nibble_acc = {nibble_acc[NIB_W-2:0], column_store[j][d]};
                    nibble_fill++;
                    if (nibble_fill == 4)
                    begin
                        nibble_stream.push_back(make_item(KIND_DATA, nibble_acc, 1'b1, 1'b0));
                        nibble_acc  = '0;
                        nibble_fill = 0;
                    end
                end
            end
        end
        parity_disk_pos = (parity_disk_pos + 1 >= dc) ? 0 : parity_disk_pos + 1;

        if (stripe_pos + 1 < sc)
        begin
            stripe_pos = (stripe_pos + 1) % 1024;
            return;
        end

        if (!set_bad && nibble_fill != 0)
            nibble_stream.push_back(make_item(KIND_DATA, NIB_W'(nibble_acc << (4 - nibble_fill)),
                                              1'b1, 1'b0));
        nibble_stream.push_back(make_item(KIND_STATUS, '0, !set_bad, 1'b1));
        stripe_pos      = 0;
        parity_disk_pos = 0;
        set_bad         = 1'b0;
        nibble_acc      = '0;
        nibble_fill     = 0;
    endtask

    // Leaves valid high on return; settle_block, or an idle gap in the next call, lowers it.
    task automatic send_column(input logic [DISK_W-1:0] bits, input logic [DISK_W-1:0] erased);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        disk_bits   <= bits;
        erased_mask <= erased;
        do @(posedge clk); while (!in_ready);
        repair_and_pack(bits, erased);
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        while (nibble_stream.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] data;
        data      = CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_DISK_COUNT:   disk_count_reg   = data[DC_W-1:0];
            CFG_BLOCK_BITS:   block_bits_reg   = data[BB_W-1:0];
            CFG_STRIPE_COUNT: stripe_count_reg = data[SC_W-1:0];
            CFG_PARITY_ODD:   parity_odd_reg   = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int dc, input int bb, input int sc, input int odd);
        write_reg(CFG_DISK_COUNT, dc);
        write_reg(CFG_BLOCK_BITS, bb);
        write_reg(CFG_STRIPE_COUNT, sc);
        write_reg(CFG_PARITY_ODD, odd);
    endtask

    // Two disks, one bit, one stripe: every column is a whole set.
    task automatic test_reset_defaults();
        send_column(8'h00, 8'h00);
        send_column(8'h03, 8'h00);
        send_column(8'h01, 8'h00);
        send_column(8'h01, 8'h02);
        send_column(8'hFC, 8'hFC);
        send_column(8'h03, 8'h03);
        settle_block();
    endtask

    task automatic test_single_repair();
        configure(8, 2, 2, 1);
        send_column(8'h7F, 8'h80);
        send_column(8'hFF, 8'h01);
        send_column(8'h00, 8'h01);
        send_column(8'hFE, 8'h00);
        settle_block();
    endtask

    task automatic test_invalid_set();
        configure(4, 2, 2, 0);
        send_column(8'h0F, 8'h03);
        send_column(8'h05, 8'h00);
        send_column(8'h0F, 8'h00);
        send_column(8'h01, 8'h00);
        settle_block();
    endtask

    // Shrinks disk count, block size and stripe count while a set is open.
    task automatic test_midset_changes();
        logic [DISK_W-1:0] b;
        logic [DISK_W-1:0] e;
        configure(5, 2, 1023, 0);
        for (int i = 0; i < 6; i++)
        begin
            make_column(1'b0, b, e);
            send_column(b, e);
        end
        settle_block();
        write_reg(CFG_DISK_COUNT, 3);
        make_column(1'b0, b, e);
        send_column(b, e);
        settle_block();
        write_reg(CFG_BLOCK_BITS, 1);
        make_column(1'b0, b, e);
        send_column(b, e);
        settle_block();
        write_reg(CFG_STRIPE_COUNT, 2);
        make_column(1'b0, b, e);
        send_column(b, e);
        settle_block();
    endtask

    task automatic test_random_sets();
        int                sent;
        int                set_no;
        int                dc;
        int                bb;
        int                sc;
        int                r;
        int                columns;
        bit                noisy;
        logic [DISK_W-1:0] b;
        logic [DISK_W-1:0] e;
        sent   = 0;
        set_no = 0;
        while (sent < RANDOM_COLUMNS)
        begin
            if (set_no == 0)
            begin
                dc = 8;
                bb = 32;
                sc = 1;
            end
            else if (set_no == 1)
            begin
                dc = 2;
                bb = 1;
                sc = 1;
            end
            else
            begin
                r  = $urandom_range(0, 8);
                dc = ($urandom_range(0, 9) == 0) ? ((r < 2) ? r : r + 7) : $urandom_range(2, 8);
                r  = $urandom_range(0, 19);
                bb = (r == 0) ? 0 : (r == 1) ? $urandom_range(33, 63) : (r == 2) ? 32
                   : $urandom_range(1, 8);
                if (bb > 8)
                    sc = $urandom_range(0, 1);
                else
                    sc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            end
            configure(dc, bb, sc, $urandom_range(0, 1));
            no_idle = ($urandom_range(0, 3) == 0);
            noisy   = ($urandom_range(0, 4) == 0);
            columns = eff_block_bits() * eff_stripes();
            for (int i = 0; i < columns; i++)
            begin
                make_column(noisy, b, e);
                send_column(b, e);
                sent++;
            end
            settle_block();
            set_no++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : consumer
        int gap;
        out_ready = 1'b0;
        forever
        begin
            gap = idle_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : output_compare
        unpack_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (nibble_stream.size() == 0)
            begin
                $error("unexpected item: kind %0d nibble %0h set_valid %0d last %0d",
                       kind, nibble, set_valid, last);
                error_count++;
            end
            else
            begin
                want = nibble_stream.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    error_count++;
                end
                if (nibble !== want.nibble)
                begin
                    $error("nibble: expected %0h, got %0h", want.nibble, nibble);
                    error_count++;
                end
                if (set_valid !== want.set_valid)
                begin
                    $error("set_valid: expected %0d, got %0d", want.set_valid, set_valid);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("raid_parity_repair_unpack_test: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_DISK_COUNT;
        cfg_data         = '0;
        in_valid         = 1'b0;
        disk_bits        = '0;
        erased_mask      = '0;
        error_count      = 0;
        no_idle          = 1'b0;
        disk_count_reg   = DC_W'(2);
        block_bits_reg   = BB_W'(1);
        stripe_count_reg = SC_W'(1);
        parity_odd_reg   = 1'b0;
        column_pos       = 0;
        stripe_pos       = 0;
        parity_disk_pos  = 0;
        set_bad          = 1'b0;
        nibble_acc       = '0;
        nibble_fill      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_single_repair();
        test_invalid_set();
        test_midset_changes();
        test_random_sets();
        settle_block();

        if (error_count == 0)
            $display("raid_parity_repair_unpack_test: clean");
        else
            $display("raid_parity_repair_unpack_test: errors");
        $finish;
    end

endmodule
